// ===== design/signed_binary_to_decimal_text_assert.svh =====
// Assertion macros shared by the decimal text converter.
`ifndef SIGNED_BINARY_TO_DECIMAL_TEXT_ASSERT_SVH
`define SIGNED_BINARY_TO_DECIMAL_TEXT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Antecedent in one cycle implies consequent in the same cycle.
`define SB2DT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Antecedent in one cycle implies consequent in the next cycle.
`define SB2DT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define SB2DT_ASSERT_IMP(lbl, ante, cons)
`define SB2DT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/sb2dt_pkg.sv =====
// Types and constants for the signed binary to decimal text converter.
`default_nettype none

package sb2dt_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int CHAR_BITS   = 6;

	// ASCII codes, kept to the six bits of the character field.
	localparam logic [CHAR_BITS-1:0] CH_ZERO  = 6'd48;
	localparam logic [CHAR_BITS-1:0] CH_MINUS = 6'd45;
	localparam logic [CHAR_BITS-1:0] CH_NINE  = 6'd57;

	// Double dabble adds three to any BCD digit at or above this.
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGITS
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit_sign;
		logic emit_digit;
		logic skip;
	} cmd_t;

	typedef struct packed {
		logic last_bit;
		logic neg;
		logic top_zero;
		logic one_left;
		logic started;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ===== design/sb2dt_ctrl.sv =====
// Controller state machine for the decimal text converter.
`default_nettype none

module sb2dt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             value_valid,
	output logic                  value_stall,
	input  wire sb2dt_pkg::stat_t stat,
	output sb2dt_pkg::cmd_t       cmd
);
	import sb2dt_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   skip_ok;

	// Leading zeros are dropped until the first printed digit; the units
	// digit is always printed.
	assign skip_ok = stat.top_zero && !stat.started && !stat.one_left;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (value_valid) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (stat.last_bit) state_d = stat.neg ? ST_SIGN : ST_DIGITS;
			end
			ST_SIGN: begin
				if (stat.out_free) state_d = ST_DIGITS;
			end
			ST_DIGITS: begin
				if (!skip_ok && stat.out_free && stat.one_left) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		value_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				value_stall = 1'b0;
				cmd.load    = value_valid;
			end
			ST_CONV: begin
				cmd.step = 1'b1;
			end
			ST_SIGN: begin
				cmd.emit_sign = stat.out_free;
			end
			ST_DIGITS: begin
				cmd.skip       = skip_ok;
				cmd.emit_digit = !skip_ok && stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/sb2dt_dpath.sv =====
// Datapath: magnitude, shift-add-3 BCD register and output register.
`default_nettype none

module sb2dt_dpath #(
	parameter int VALUE_BITS = 64,
	parameter int DIGITS     = 20
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic signed [sb2dt_pkg::VALUE_WIDTH-1:0] value,
	input  wire sb2dt_pkg::cmd_t                        cmd,
	output sb2dt_pkg::stat_t                            stat,
	output logic [sb2dt_pkg::CHAR_BITS-1:0]             character,
	output logic                                        last_char,
	output logic                                        char_valid,
	input  wire logic                                   char_stall
);
	import sb2dt_pkg::*;

	localparam int BCD_BITS = 4 * DIGITS;
	localparam int BC_W     = $clog2(VALUE_BITS + 1);
	localparam int DC_W     = $clog2(DIGITS + 1);

	logic [VALUE_BITS-1:0] v_in;
	logic                  neg_in;
	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic [BCD_BITS-1:0]   bcd_adj;
	logic [BC_W-1:0]       bit_cnt_q;
	logic [DC_W-1:0]       dig_cnt_q;
	logic                  neg_q;
	logic                  started_q;
	logic [CHAR_BITS-1:0]  char_q;
	logic                  last_q;
	logic                  valid_q;
	logic [3:0]            top_digit;
	logic                  out_free;

	assign v_in      = value[VALUE_BITS-1:0];
	assign neg_in    = v_in[VALUE_BITS-1];
	assign top_digit = bcd_q[BCD_BITS-1 -: 4];
	assign out_free  = !valid_q || !char_stall;

	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= BCD_ADJ_MIN) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + BCD_ADJ_ADD;
			end
		end
	end

	// Control-side registers: counters, flags and the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
			neg_q     <= 1'b0;
			started_q <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				bit_cnt_q <= BC_W'(VALUE_BITS);
				dig_cnt_q <= DC_W'(DIGITS);
				neg_q     <= neg_in;
				started_q <= 1'b0;
			end
			if (cmd.step) bit_cnt_q <= bit_cnt_q - BC_W'(1);
			if (cmd.skip || cmd.emit_digit) dig_cnt_q <= dig_cnt_q - DC_W'(1);
			if (cmd.emit_digit) started_q <= 1'b1;
			if (cmd.emit_sign || cmd.emit_digit) begin
				valid_q <= 1'b1;
			end else if (!char_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= neg_in ? (~v_in + VALUE_BITS'(1)) : v_in;
			bcd_q <= '0;
		end else if (cmd.step) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_BITS-2:0], mag_q[VALUE_BITS-1]};
		end else if (cmd.skip || cmd.emit_digit) begin
			bcd_q <= {bcd_q[BCD_BITS-5:0], 4'd0};
		end
		if (cmd.emit_sign) begin
			char_q <= CH_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= CH_ZERO + {2'b00, top_digit};
			last_q <= (dig_cnt_q == DC_W'(1));
		end
	end

	assign stat.last_bit = (bit_cnt_q == BC_W'(1));
	assign stat.neg      = neg_q;
	assign stat.top_zero = (top_digit == 4'd0);
	assign stat.one_left = (dig_cnt_q == DC_W'(1));
	assign stat.started  = started_q;
	assign stat.out_free = out_free;

	assign character  = char_q;
	assign last_char  = last_q;
	assign char_valid = valid_q;

endmodule

`default_nettype wire

// ===== design/signed_binary_to_decimal_text.sv =====
// Sequence: accept the value, a shift-add-3 step for each of its VALUE_BITS bits,
// a minus sign if negative, then each text digit slot (leading zeros are skipped one
// per cycle; printed characters wait while the output is stalled). A new value is
// taken only after the last character of the previous one is loaded for output.
// Reset: arst_n clears the controller and output valid; no transfer is pending.
`default_nettype none
`include "signed_binary_to_decimal_text_assert.svh"

module signed_binary_to_decimal_text #(
	parameter int VALUE_BITS = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic signed [sb2dt_pkg::VALUE_WIDTH-1:0] value,
	input  wire logic                                   value_valid,
	output logic                                        value_stall,
	output logic [sb2dt_pkg::CHAR_BITS-1:0]             character,
	output logic                                        last_char,
	output logic                                        char_valid,
	input  wire logic                                   char_stall
);
	import sb2dt_pkg::*;

	// Enough digits for the magnitude 2^(VALUE_BITS-1).
	localparam int DIGITS = (VALUE_BITS * 3) / 10 + 1;

	cmd_t  cmd;
	stat_t stat;

	sb2dt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.stat        (stat),
		.cmd         (cmd)
	);

	sb2dt_dpath #(
		.VALUE_BITS (VALUE_BITS),
		.DIGITS     (DIGITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.cmd        (cmd),
		.stat       (stat),
		.character  (character),
		.last_char  (last_char),
		.char_valid (char_valid),
		.char_stall (char_stall)
	);

	// Once a value is taken, no other is taken until its text is done.
	`SB2DT_ASSERT_NEXT(a_busy_after_load, value_valid && !value_stall, value_stall)
	// A minus sign is only produced for a negative value.
	`SB2DT_ASSERT_IMP(a_sign_only_neg, cmd.emit_sign, stat.neg)
	// Every shown character is a minus sign or a decimal digit.
	`SB2DT_ASSERT_IMP(a_char_legal, char_valid,
		(character == CH_MINUS) || ((character >= CH_ZERO) && (character <= CH_NINE)))
	// A minus sign is never the last character.
	`SB2DT_ASSERT_IMP(a_sign_not_last, char_valid && (character == CH_MINUS), !last_char)

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the signed binary to decimal text converter.
`timescale 1ns / 1ps

module tb_top;
	import sb2dt_pkg::*;

	localparam int DUT_BITS      = 64;
	localparam int MAX_TEXT      = 20;
	localparam int SETTLE_CYCLES = 120;
	localparam int LONG_HOLD     = 400;
	localparam int WATCHDOG_MAX  = 5000;

	typedef struct packed {
		logic [CHAR_BITS-1:0] code;
		logic                 last;
	} text_char_t;

	logic                        clk    = 1'b0;
	logic                        arst_n = 1'b0;
	logic signed [VALUE_WIDTH-1:0] value = '0;
	logic                        value_valid = 1'b0;
	logic                        value_stall;
	logic [CHAR_BITS-1:0]        character;
	logic                        last_char;
	logic                        char_valid;
	logic                        char_stall = 1'b0;

	logic [VALUE_WIDTH-1:0] pend_q[$];
	text_char_t             text_q[$];

	int  n_queued    = 0;
	int  n_accepted  = 0;
	int  n_chars     = 0;
	int  n_errors    = 0;
	int  gap_left    = 0;
	int  stall_left  = 0;
	int  hold_left   = 0;
	int  quiet_count = 0;
	bit  idle_on     = 1'b1;
	bit  hold_go     = 1'b0;
	bit  hold_started = 1'b0;

	signed_binary_to_decimal_text #(
		.VALUE_BITS(DUT_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.value_valid(value_valid),
		.value_stall(value_stall),
		.character  (character),
		.last_char  (last_char),
		.char_valid (char_valid),
		.char_stall (char_stall)
	);

	always #10 clk = ~clk;

	// Appends the expected decimal text of one accepted value.
	function automatic void push_decimal_text(logic [VALUE_WIDTH-1:0] raw);
		logic [VALUE_WIDTH-1:0] mask;
		logic [VALUE_WIDTH-1:0] v;
		logic [VALUE_WIDTH-1:0] mag;
		logic [3:0]             digs[MAX_TEXT];
		int                     nd;
		bit                     neg;
		mask = (DUT_BITS >= 64) ? '1 : ((64'd1 << DUT_BITS) - 64'd1);
		v    = raw & mask;
		neg  = v[DUT_BITS-1];
		// The magnitude is unsigned, so the most negative value needs no special path.
		mag  = neg ? ((~v + 64'd1) & mask) : v;
		nd   = 0;
		do begin
			digs[nd] = 4'(mag % 64'd10);
			mag      = mag / 64'd10;
			nd++;
		end while (mag != 0 && nd < MAX_TEXT);
		if (neg)
			text_q.push_back('{CH_MINUS, 1'b0});
		for (int i = nd - 1; i >= 0; i--)
			text_q.push_back('{CH_ZERO + CHAR_BITS'(digs[i]), i == 0});
	endfunction

	// Random mix of full-width values, short magnitudes and powers of ten near their edges.
	function automatic logic [VALUE_WIDTH-1:0] rand_value();
		logic [VALUE_WIDTH-1:0] v;
		int                     w;
		int                     p;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				v = {$urandom, $urandom};
			end
			4, 5, 6, 7: begin
				w = $urandom_range(1, 63);
				v = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
			default: begin
				p = $urandom_range(0, 18);
				v = 64'd1;
				repeat (p) v = v * 64'd10;
				v = v + 64'($urandom_range(0, 2)) - 64'd1;
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
		endcase
		return v;
	endfunction

	// Driver: offers pending values, holding each one steady while it is stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_valid <= 1'b0;
			value       <= '0;
			gap_left    <= 0;
		end else begin
			if (value_valid && !value_stall) begin
				push_decimal_text(value);
				n_accepted++;
			end
			if (!value_valid || !value_stall) begin
				if (gap_left != 0) begin
					gap_left    <= gap_left - 1;
					value_valid <= 1'b0;
				end else if (pend_q.size() != 0) begin
					value       <= pend_q.pop_front();
					value_valid <= 1'b1;
					if (idle_on && $urandom_range(0, 3) == 0)
						gap_left <= $urandom_range(1, 10);
				end else begin
					value_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each character transfer and drives the output stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_stall   <= 1'b0;
			stall_left   <= 0;
			hold_left    <= 0;
			hold_started <= 1'b0;
		end else begin
			if (char_valid && !char_stall) begin
				n_chars++;
				if (text_q.size() == 0) begin
					$display("%0t: unexpected character %0d last %0b", $time,
						character, last_char);
					n_errors++;
				end else begin
					if (character !== text_q[0].code) begin
						$display("%0t: character expected %0d actual %0d", $time,
							text_q[0].code, character);
						n_errors++;
					end
					if (last_char !== text_q[0].last) begin
						$display("%0t: last_char expected %0b actual %0b", $time,
							text_q[0].last, last_char);
						n_errors++;
					end
					void'(text_q.pop_front());
				end
			end
			if (hold_go && !hold_started) begin
				hold_started <= 1'b1;
				hold_left    <= LONG_HOLD;
				char_stall   <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left  <= hold_left - 1;
				char_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				char_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				stall_left <= $urandom_range(0, 9);
				char_stall <= 1'b1;
			end else begin
				char_stall <= 1'b0;
			end
		end
	end

	// Watchdog: ends the run when neither side has moved a transfer for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((value_valid && !value_stall) || (char_valid && !char_stall))
				quiet_count <= 0;
			else
				quiet_count <= quiet_count + 1;
			if (quiet_count >= WATCHDOG_MAX) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_count);
				$display("[signed_binary_to_decimal_text] ERROR");
				$finish;
			end
		end
	end

	task automatic queue_value(logic [VALUE_WIDTH-1:0] v);
		pend_q.push_back(v);
		n_queued++;
	endtask

	task automatic queue_random(int count);
		repeat (count) queue_value(rand_value());
	endtask

	task automatic wait_drained();
		while (n_accepted != n_queued || text_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: zero, single digits, decade edges, the most negative value and wide words.
		queue_value(64'd0);
		queue_value(64'd1);
		queue_value(-64'd1);
		queue_value(64'd9);
		queue_value(64'd10);
		queue_value(-64'd10);
		queue_value(64'd99);
		queue_value(64'd100);
		queue_value(-64'd5);
		queue_value(64'h7FFF_FFFF_FFFF_FFFF);
		queue_value(64'h8000_0000_0000_0000);
		queue_value(64'h8000_0000_0000_0001);
		queue_value(64'd1000000000000000000);
		queue_value(64'd999999999999999999);
		queue_value(-64'd1000000000000000000);
		queue_value(64'd1234567890123456789);
		queue_value(64'h0000_0000_FFFF_FFFF);
		queue_value(64'hFFFF_FFFF_0000_0000);
		queue_value(64'hAAAA_AAAA_AAAA_AAAA);
		queue_value(64'h5555_5555_5555_5555);
		wait_drained();

		// The receiver holds off for a long stretch while values keep coming.
		queue_random(200);
		hold_go = 1'b1;
		// The sender then pauses until every character has arrived.
		wait_drained();

		queue_random(200);
		wait_drained();

		idle_on = 1'b0;
		queue_random(100);
		wait_drained();

		$display("Converted %0d values into %0d characters, with random gaps, stalls",
			n_accepted, n_chars);
		$display("and one long output hold-off; the last 100 values ran with no idling.");
		if (n_errors == 0) begin
			$display("[signed_binary_to_decimal_text] OK");
		end else begin
			$display("[signed_binary_to_decimal_text] ERROR");
		end
		$finish;
	end

endmodule
